[rtl/deadlock_detector_assert.svh]
// Assertion macros for the deadlock detector.
// Each macro checks on the rising edge of clk and is disabled during reset.
`ifndef DEADLOCK_DETECTOR_ASSERT_SVH
`define DEADLOCK_DETECTOR_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication.
`define DD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deadlock_detector: same-cycle check failed");
// Next-cycle implication.
`define DD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deadlock_detector: next-cycle check failed");
`else
`define DD_ASSERT_IMP(label, ante, cons)
`define DD_ASSERT_NXT(label, ante, cons)
`endif

`endif

[rtl/dd_pkg.sv]
`timescale 1ns / 1ps

package dd_pkg;

  localparam int MAX_PROCS  = 16;
  localparam int MAX_RES    = 16;
  localparam int COUNT_BITS = 8;

  localparam int WORK_BITS = 12;
  localparam int SUM_BITS  = ((WORK_BITS > COUNT_BITS) ? WORK_BITS : COUNT_BITS) + 1;

  localparam int P_BITS    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int R_BITS    = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
  localparam int ADDR_BITS = (MAX_PROCS * MAX_RES > 1) ? $clog2(MAX_PROCS * MAX_RES) : 1;

  // Fixed field widths of the ports
  localparam int OPCODE_BITS   = 2;
  localparam int INDEX_BITS    = 4;
  localparam int IN_COUNT_BITS = 8;
  localparam int PROC_ID_BITS  = 4;

  // Configuration port
  localparam int CFG_BITS       = 5;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_ADDR_BITS  = 3;

  localparam logic [CFG_BITS-1:0] PROC_COUNT_RST = 5'd16;
  localparam logic [CFG_BITS-1:0] RES_COUNT_RST  = 5'd16;

  // Register indexes, selected by paddr[2]
  localparam logic REG_PROC_COUNT = 1'b0;
  localparam logic REG_RES_COUNT  = 1'b1;

  // Opcodes
  localparam logic [OPCODE_BITS-1:0] OP_LOAD_AVAIL = 2'd0;
  localparam logic [OPCODE_BITS-1:0] OP_LOAD_ROW   = 2'd1;
  localparam logic [OPCODE_BITS-1:0] OP_RUN        = 2'd2;

  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [WORK_BITS-1:0]  work_t;
  typedef logic [SUM_BITS-1:0]   sum_t;
  typedef logic [P_BITS-1:0]     pidx_t;
  typedef logic [R_BITS-1:0]     ridx_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;

  typedef cnt_t avail_arr_t [MAX_RES];

  localparam work_t WORK_MAX = '1;

  // Table write request from the load decoder
  typedef struct packed {
    logic  row_we;
    logic  avail_we;
    addr_t addr;
    ridx_t res;
    cnt_t  avail;
    cnt_t  held;
    cnt_t  wanted;
  } tbl_wr_t;

  // Table read request from the sequencer
  typedef struct packed {
    logic  en;
    addr_t addr;
  } tbl_rd_t;

  function automatic work_t work_sat(input sum_t s);
    work_sat = (s > sum_t'(WORK_MAX)) ? WORK_MAX : s[WORK_BITS-1:0];
  endfunction

  function automatic addr_t addr_of(input pidx_t p, input ridx_t r);
    addr_of = addr_t'(p) * addr_t'(MAX_RES) + addr_t'(r);
  endfunction

endpackage

[rtl/dd_tables.sv]
`timescale 1ns / 1ps

module dd_tables (
  input  logic               clk,
  input  dd_pkg::tbl_wr_t    wr_i,
  input  dd_pkg::tbl_rd_t    rd_i,
  output dd_pkg::cnt_t       held_q_o,
  output dd_pkg::cnt_t       req_q_o,
  output dd_pkg::avail_arr_t avail_o
);
  import dd_pkg::*;

  cnt_t held_mem [MAX_PROCS * MAX_RES];
  cnt_t req_mem  [MAX_PROCS * MAX_RES];
  cnt_t avail_r  [MAX_RES];
  cnt_t held_q_r;
  cnt_t req_q_r;

  // Process rows: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_i.row_we) begin
      held_mem[wr_i.addr] <= wr_i.held;
      req_mem[wr_i.addr]  <= wr_i.wanted;
    end
    if (rd_i.en) begin
      held_q_r <= held_mem[rd_i.addr];
      req_q_r  <= req_mem[rd_i.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_i.avail_we) begin
      avail_r[wr_i.res] <= wr_i.avail;
    end
  end

  assign held_q_o = held_q_r;
  assign req_q_o  = req_q_r;
  assign avail_o  = avail_r;

endmodule

[rtl/dd_unit.sv]
`timescale 1ns / 1ps

module dd_unit (
  input  dd_pkg::work_t work_i,
  input  dd_pkg::cnt_t  oper_i,
  output dd_pkg::work_t sum_o,
  output logic          gt_o,
  output logic          nz_o
);
  import dd_pkg::*;

  // Saturating add, request compare and nonzero test on one work entry
  assign sum_o = work_sat(sum_t'(work_i) + sum_t'(oper_i));
  assign gt_o  = sum_t'(oper_i) > sum_t'(work_i);
  assign nz_o  = (oper_i != '0);

endmodule

[rtl/deadlock_detector.sv]
`timescale 1ns / 1ps

// Multi-instance deadlock detector. Load words (available counts, and held
// and wanted counts per process and resource) are accepted while the block
// is idle and can arrive back to back. A run word starts detection and holds
// in_stall high until the last verdict has been handed to the output
// register. A run first scans all processes for empty ones, then per pass
// selects each process in turn, tests each unfinished process resource by
// resource and releases the holdings of each process that finishes; passes
// repeat until one finishes nobody (at most np+1 passes), then np verdict
// words follow, one per cycle while the output is not stalled. The walks
// step one resource at a time because the process tables have one
// registered read port and one compare/add unit is shared by all steps.
// np and nr are proc_count and res_count as clamped to 1..16. The result
// register lets the next word be accepted while the last verdict still waits.
module deadlock_detector (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [dd_pkg::OPCODE_BITS-1:0]      in_opcode,
  input  logic [dd_pkg::INDEX_BITS-1:0]       in_proc_index,
  input  logic [dd_pkg::INDEX_BITS-1:0]       in_res_index,
  input  logic [dd_pkg::IN_COUNT_BITS-1:0]    in_available_count,
  input  logic [dd_pkg::IN_COUNT_BITS-1:0]    in_held_count,
  input  logic [dd_pkg::IN_COUNT_BITS-1:0]    in_wanted_count,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [dd_pkg::PROC_ID_BITS-1:0]     out_proc_id,
  output logic                                out_is_deadlocked,
  output logic                                out_any_deadlock,
  output logic                                out_last,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dd_pkg::CFG_ADDR_BITS-1:0]    paddr,
  input  logic [dd_pkg::CFG_DATA_BITS-1:0]    pwdata,
  output logic [dd_pkg::CFG_DATA_BITS-1:0]    prdata,
  output logic                                pready
);
  import dd_pkg::*;

  `include "deadlock_detector_assert.svh"

  typedef enum logic [3:0] {
    S_IDLE,
    S_EMPTY_RD,
    S_EMPTY_CHK,
    S_SCAN,
    S_TEST_RD,
    S_TEST_CHK,
    S_REL_RD,
    S_REL_ADD,
    S_EMIT
  } state_t;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [CFG_BITS-1:0] proc_count_r;
  logic [CFG_BITS-1:0] res_count_r;
  logic                cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proc_count_r <= PROC_COUNT_RST;
      res_count_r  <= RES_COUNT_RST;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_PROC_COUNT: proc_count_r <= pwdata[CFG_BITS-1:0];
        REG_RES_COUNT:  res_count_r  <= pwdata[CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_RES_COUNT) ? CFG_DATA_BITS'(res_count_r)
                                              : CFG_DATA_BITS'(proc_count_r);

  // Last process and resource index of a run; zero acts as one, and a count
  // above the table size acts as the table size.
  pidx_t p_last;
  ridx_t r_last;

  always_comb begin
    if (proc_count_r == '0) begin
      p_last = '0;
    end else if (32'(proc_count_r) > MAX_PROCS) begin
      p_last = P_BITS'(MAX_PROCS - 1);
    end else begin
      p_last = P_BITS'(proc_count_r - CFG_BITS'(1));
    end
    if (res_count_r == '0) begin
      r_last = '0;
    end else if (32'(res_count_r) > MAX_RES) begin
      r_last = R_BITS'(MAX_RES - 1);
    end else begin
      r_last = R_BITS'(res_count_r - CFG_BITS'(1));
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------
  state_t                  state_r, state_nxt;
  pidx_t                   p_r, p_nxt;
  ridx_t                   r_r, r_nxt;
  logic                    empty_r, empty_nxt;
  logic                    changed_r, changed_nxt;
  logic                    any_r, any_nxt;
  logic [MAX_PROCS-1:0]    fin_r, fin_nxt;
  work_t                   work_r [MAX_RES];
  work_t                   work_nxt [MAX_RES];

  logic                    out_valid_r, out_valid_nxt;
  logic [PROC_ID_BITS-1:0] out_id_r, out_id_nxt;
  logic                    out_dead_r, out_dead_nxt;
  logic                    out_any_r, out_any_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    in_acc;
  logic                    emit_load;
  tbl_wr_t                 tbl_wr;
  tbl_rd_t                 tbl_rd;
  cnt_t                    held_q;
  cnt_t                    req_q;
  avail_arr_t              avail;
  cnt_t                    unit_oper;
  work_t                   unit_sum;
  logic                    unit_gt;
  logic                    unit_nz;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid & ~in_stall;

  // Load decode: out-of-range indexes drop the word
  always_comb begin
    tbl_wr          = '0;
    tbl_wr.addr     = addr_of(P_BITS'(in_proc_index), R_BITS'(in_res_index));
    tbl_wr.res      = R_BITS'(in_res_index);
    tbl_wr.avail    = COUNT_BITS'(in_available_count);
    tbl_wr.held     = COUNT_BITS'(in_held_count);
    tbl_wr.wanted   = COUNT_BITS'(in_wanted_count);
    tbl_wr.avail_we = in_acc && (in_opcode == OP_LOAD_AVAIL) &&
                      (32'(in_res_index) < MAX_RES);
    tbl_wr.row_we   = in_acc && (in_opcode == OP_LOAD_ROW) &&
                      (32'(in_proc_index) < MAX_PROCS) && (32'(in_res_index) < MAX_RES);
  end

  dd_tables u_tables (
    .clk      (clk),
    .wr_i     (tbl_wr),
    .rd_i     (tbl_rd),
    .held_q_o (held_q),
    .req_q_o  (req_q),
    .avail_o  (avail)
  );

  // The shared unit tests holdings for zero in the empty scan, compares
  // requests in the test walk and adds holdings in the release walk, always
  // against the work entry of the current resource.
  assign unit_oper = (state_r == S_TEST_CHK) ? req_q : held_q;

  dd_unit u_unit (
    .work_i (work_r[r_r]),
    .oper_i (unit_oper),
    .sum_o  (unit_sum),
    .gt_o   (unit_gt),
    .nz_o   (unit_nz)
  );

  always_comb begin
    logic adv;
    logic row_empty;
    logic dead;
    logic is_last;
    logic any_now;

    adv       = 1'b0;
    row_empty = empty_r & ~unit_nz;
    dead      = ~fin_r[p_r];
    is_last   = (p_r == p_last);
    any_now   = any_r | dead;

    state_nxt   = state_r;
    p_nxt       = p_r;
    r_nxt       = r_r;
    empty_nxt   = empty_r;
    changed_nxt = changed_r;
    any_nxt     = any_r;
    fin_nxt     = fin_r;
    work_nxt    = work_r;
    emit_load   = 1'b0;

    // Drop the result word once it is taken
    out_valid_nxt = out_valid_r & out_stall;
    out_id_nxt    = out_id_r;
    out_dead_nxt  = out_dead_r;
    out_any_nxt   = out_any_r;
    out_last_nxt  = out_last_r;

    tbl_rd.en   = 1'b0;
    tbl_rd.addr = addr_of(p_r, r_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_opcode == OP_RUN)) begin
          // Seed the work vector from the available counts
          for (int i = 0; i < MAX_RES; i++) begin
            work_nxt[i] = work_sat(sum_t'(avail[i]));
          end
          fin_nxt   = '0;
          p_nxt     = '0;
          r_nxt     = '0;
          empty_nxt = 1'b1;
          state_nxt = S_EMPTY_RD;
        end
      end

      S_EMPTY_RD: begin
        tbl_rd.en = 1'b1;
        state_nxt = S_EMPTY_CHK;
      end

      S_EMPTY_CHK: begin
        if (r_r == r_last) begin
          // A process that holds nothing counts as finished
          fin_nxt[p_r] = row_empty;
          r_nxt        = '0;
          empty_nxt    = 1'b1;
          if (is_last) begin
            p_nxt       = '0;
            changed_nxt = 1'b0;
            state_nxt   = S_SCAN;
          end else begin
            p_nxt     = p_r + P_BITS'(1);
            state_nxt = S_EMPTY_RD;
          end
        end else begin
          r_nxt     = r_r + R_BITS'(1);
          empty_nxt = row_empty;
          state_nxt = S_EMPTY_RD;
        end
      end

      S_SCAN: begin
        if (fin_r[p_r]) begin
          adv = 1'b1;
        end else begin
          r_nxt     = '0;
          state_nxt = S_TEST_RD;
        end
      end

      S_TEST_RD: begin
        tbl_rd.en = 1'b1;
        state_nxt = S_TEST_CHK;
      end

      S_TEST_CHK: begin
        if (unit_gt) begin
          adv = 1'b1;
        end else if (r_r == r_last) begin
          r_nxt     = '0;
          state_nxt = S_REL_RD;
        end else begin
          r_nxt     = r_r + R_BITS'(1);
          state_nxt = S_TEST_RD;
        end
      end

      S_REL_RD: begin
        tbl_rd.en = 1'b1;
        state_nxt = S_REL_ADD;
      end

      S_REL_ADD: begin
        work_nxt[r_r] = unit_sum;
        if (r_r == r_last) begin
          fin_nxt[p_r] = 1'b1;
          changed_nxt  = 1'b1;
          adv          = 1'b1;
        end else begin
          r_nxt     = r_r + R_BITS'(1);
          state_nxt = S_REL_RD;
        end
      end

      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          emit_load     = 1'b1;
          out_valid_nxt = 1'b1;
          out_id_nxt    = PROC_ID_BITS'(p_r);
          out_dead_nxt  = dead;
          out_any_nxt   = is_last & any_now;
          out_last_nxt  = is_last;
          any_nxt       = any_now;
          if (is_last) begin
            p_nxt     = '0;
            state_nxt = S_IDLE;
          end else begin
            p_nxt = p_r + P_BITS'(1);
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // Advance to the next process; at the end of a pass either start
    // another or, when nobody finished, move on to the verdicts.
    if (adv) begin
      if (is_last) begin
        p_nxt = '0;
        if (changed_nxt) begin
          changed_nxt = 1'b0;
          state_nxt   = S_SCAN;
        end else begin
          any_nxt   = 1'b0;
          state_nxt = S_EMIT;
        end
      end else begin
        p_nxt     = p_r + P_BITS'(1);
        state_nxt = S_SCAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      p_r         <= '0;
      r_r         <= '0;
      empty_r     <= 1'b0;
      changed_r   <= 1'b0;
      any_r       <= 1'b0;
      fin_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      p_r         <= p_nxt;
      r_r         <= r_nxt;
      empty_r     <= empty_nxt;
      changed_r   <= changed_nxt;
      any_r       <= any_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
    work_r     <= work_nxt;
    out_id_r   <= out_id_nxt;
    out_dead_r <= out_dead_nxt;
    out_any_r  <= out_any_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_proc_id       = out_id_r;
  assign out_is_deadlocked = out_dead_r;
  assign out_any_deadlock  = out_any_r;
  assign out_last          = out_last_r;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `DD_ASSERT_IMP(a_word_from_emit, $rose(out_valid), $past(state_r) == S_EMIT)
  `DD_ASSERT_IMP(a_any_on_last, out_valid && out_any_deadlock, out_last)
  `DD_ASSERT_IMP(a_test_unfinished, state_r == S_TEST_RD, !fin_r[p_r])
  `DD_ASSERT_NXT(a_last_to_idle, emit_load && (p_r == p_last), state_r == S_IDLE)

endmodule

[dv/deadlock_detector_tb.sv]
`timescale 1ns / 1ps

module deadlock_detector_tb;
  import dd_pkg::*;

  // Opcode 3 has no meaning to the block: it must be swallowed without a verdict.
  localparam logic [OPCODE_BITS-1:0] OP_UNUSED = 2'd3;

  localparam int unsigned HOLD_OFF_CYCLES = 200;
  localparam int unsigned SETTLE_CYCLES   = 16;
  localparam int unsigned LIMIT_NS        = 100_000_000;

  typedef struct packed {
    logic [PROC_ID_BITS-1:0] proc_id;
    logic                    is_deadlocked;
    logic                    any_deadlock;
    logic                    last;
  } verdict_t;

  // Mirror of the block's tables and counts. A run word turns the tables into
  // one verdict per process, queued in process order.
  class verdict_board;
    cnt_t                held_tbl   [MAX_PROCS][MAX_RES];
    cnt_t                wanted_tbl [MAX_PROCS][MAX_RES];
    cnt_t                free_tbl   [MAX_RES];
    logic [CFG_BITS-1:0] proc_count_reg;
    logic [CFG_BITS-1:0] res_count_reg;
    verdict_t            expected_verdicts [$];
    int                  errors;

    function new();
      proc_count_reg = PROC_COUNT_RST;
      res_count_reg  = RES_COUNT_RST;
      errors         = 0;
    endfunction

    // A count of zero means one; anything past the table size means all of it.
    function int active_span(logic [CFG_BITS-1:0] raw, int limit);
      if (raw == '0) return 1;
      return (int'(raw) > limit) ? limit : int'(raw);
    endfunction

    function int procs_in_use();
      return active_span(proc_count_reg, MAX_PROCS);
    endfunction

    function int res_in_use();
      return active_span(res_count_reg, MAX_RES);
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction

    function void note_config(logic sel, logic [CFG_BITS-1:0] value);
      if (sel == REG_PROC_COUNT) proc_count_reg = value;
      else res_count_reg = value;
    endfunction

    // Release processes until none can finish, then queue the verdicts.
    function void predict_verdicts();
      int                   np;
      int                   nr;
      work_t                work [MAX_RES];
      logic [MAX_PROCS-1:0] finished;
      logic                 progress;
      logic                 fits;
      logic                 seen_dead;
      int unsigned          total;
      verdict_t             v;
      np = procs_in_use();
      nr = res_in_use();
      finished  = '0;
      seen_dead = 1'b0;
      for (int r = 0; r < nr; r++) work[r] = work_t'(free_tbl[r]);
      // Processes holding nothing are done before the first pass.
      for (int p = 0; p < np; p++) begin
        finished[p] = 1'b1;
        for (int r = 0; r < nr; r++) if (held_tbl[p][r] != '0) finished[p] = 1'b0;
      end
      do begin
        progress = 1'b0;
        for (int p = 0; p < np; p++) begin
          if (!finished[p]) begin
            fits = 1'b1;
            for (int r = 0; r < nr; r++) if (wanted_tbl[p][r] > work[r]) fits = 1'b0;
            if (fits) begin
              finished[p] = 1'b1;
              progress    = 1'b1;
              for (int r = 0; r < nr; r++) begin
                total   = int'(work[r]) + int'(held_tbl[p][r]);
                work[r] = (total > int'(WORK_MAX)) ? WORK_MAX : work_t'(total);
              end
            end
          end
        end
      end while (progress);
      for (int p = 0; p < np; p++) begin
        v.proc_id       = PROC_ID_BITS'(p);
        v.is_deadlocked = !finished[p];
        seen_dead       = seen_dead | !finished[p];
        v.last          = (p == np - 1);
        v.any_deadlock  = v.last & seen_dead;
        expected_verdicts.push_back(v);
      end
    endfunction

    function void note_word(logic [OPCODE_BITS-1:0] op, logic [INDEX_BITS-1:0] pi,
                            logic [INDEX_BITS-1:0] ri, cnt_t free_n, cnt_t held_n,
                            cnt_t wanted_n);
      case (op)
        OP_LOAD_AVAIL: free_tbl[ri] = free_n;
        OP_LOAD_ROW: begin
          held_tbl[pi][ri]   = held_n;
          wanted_tbl[pi][ri] = wanted_n;
        end
        OP_RUN: predict_verdicts();
        default: ;
      endcase
    endfunction

    function void report_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_verdict(logic [PROC_ID_BITS-1:0] pid, logic dead, logic any_dead,
                                logic last);
      verdict_t want;
      if (expected_verdicts.size() == 0) begin
        $display("%0t: verdict for process %0d with none outstanding, expected nothing,",
                 $time, pid);
        $display("  actual dead=%0b any=%0b last=%0b", dead, any_dead, last);
        errors++;
        return;
      end
      want = expected_verdicts.pop_front();
      report_field("proc_id", want.proc_id, pid);
      report_field("is_deadlocked", want.is_deadlocked, dead);
      report_field("any_deadlock", want.any_deadlock, any_dead);
      report_field("last", want.last, last);
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [OPCODE_BITS-1:0]     in_opcode = '0;
  logic [INDEX_BITS-1:0]      in_proc_index = '0;
  logic [INDEX_BITS-1:0]      in_res_index = '0;
  logic [IN_COUNT_BITS-1:0]   in_available_count = '0;
  logic [IN_COUNT_BITS-1:0]   in_held_count = '0;
  logic [IN_COUNT_BITS-1:0]   in_wanted_count = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b1;
  logic [PROC_ID_BITS-1:0]    out_proc_id;
  logic                       out_is_deadlocked;
  logic                       out_any_deadlock;
  logic                       out_last;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0]   paddr = '0;
  logic [CFG_DATA_BITS-1:0]   pwdata = '0;
  logic [CFG_DATA_BITS-1:0]   prdata;
  logic                       pready;

  verdict_board board = new();

  // Track which table entries hold data, so a run never reads an empty entry.
  bit          free_loaded [MAX_RES];
  bit          row_loaded  [MAX_PROCS][MAX_RES];
  int unsigned send_calm;
  int unsigned sink_calm;
  int          readback_errors = 0;
  bit          held_off = 1'b0;

  deadlock_detector dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Draw a random wait, with occasional calm stretches of no waiting.
  function automatic int unsigned pick_gap(ref int unsigned calm);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 15);
  endfunction

  // Lean on small counts so runs land on both sides of the finish test;
  // keep the extremes and the full range in the mix.
  function automatic cnt_t pick_count();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return cnt_t'($urandom_range(0, 3));
      6:                return '0;
      7:                return '1;
      default:          return cnt_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly hit entries in use; sometimes any entry of the table.
  function automatic logic [INDEX_BITS-1:0] pick_index(int span);
    if ($urandom_range(0, 4) == 0) return INDEX_BITS'($urandom_range(0, 15));
    return INDEX_BITS'($urandom_range(0, span - 1));
  endfunction

  // Offer one word and hold it until accepted. Enter and leave at a falling edge.
  task automatic offer_word(input logic [OPCODE_BITS-1:0] op,
                            input logic [INDEX_BITS-1:0] pi, input logic [INDEX_BITS-1:0] ri,
                            input cnt_t free_n, input cnt_t held_n, input cnt_t wanted_n);
    int unsigned gap;
    gap = pick_gap(send_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_opcode          <= op;
    in_proc_index      <= pi;
    in_res_index       <= ri;
    in_available_count <= free_n;
    in_held_count      <= held_n;
    in_wanted_count    <= wanted_n;
    in_valid           <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_word(op, pi, ri, free_n, held_n, wanted_n);
    if (op == OP_LOAD_AVAIL) free_loaded[ri] = 1'b1;
    else if (op == OP_LOAD_ROW) row_loaded[pi][ri] = 1'b1;
    @(negedge clk);
  endtask

  task automatic load_free(input int ri, input cnt_t free_n);
    offer_word(OP_LOAD_AVAIL, INDEX_BITS'($urandom_range(0, 15)), INDEX_BITS'(ri), free_n,
               cnt_t'($urandom_range(0, 255)), cnt_t'($urandom_range(0, 255)));
  endtask

  task automatic load_row(input int pi, input int ri, input cnt_t held_n, input cnt_t wanted_n);
    offer_word(OP_LOAD_ROW, INDEX_BITS'(pi), INDEX_BITS'(ri), cnt_t'($urandom_range(0, 255)),
               held_n, wanted_n);
  endtask

  // Load every entry in use that has never been written. Heavy fills give each
  // process a holding of 255 of every resource so the work sums run into saturation.
  task automatic fill_tables(input bit heavy);
    for (int r = 0; r < board.res_in_use(); r++)
      if (!free_loaded[r]) load_free(r, pick_count());
    for (int p = 0; p < board.procs_in_use(); p++)
      for (int r = 0; r < board.res_in_use(); r++)
        if (!row_loaded[p][r]) load_row(p, r, heavy ? cnt_t'('1) : pick_count(), pick_count());
  endtask

  // Run fields other than the opcode carry noise: the block must ignore them.
  task automatic start_scan();
    fill_tables(1'b0);
    offer_word(OP_RUN, INDEX_BITS'($urandom_range(0, 15)), INDEX_BITS'($urandom_range(0, 15)),
               cnt_t'($urandom_range(0, 255)), cnt_t'($urandom_range(0, 255)),
               cnt_t'($urandom_range(0, 255)));
  endtask

  // Drop valid, drain every verdict, then give trailing load words time to land.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Setup and access cycle for the write, then read the register back.
  task automatic write_count(input logic sel, input logic [CFG_BITS-1:0] value);
    logic [CFG_DATA_BITS-1:0] wdata;
    logic [CFG_DATA_BITS-1:0] rdata;
    wdata                 = $urandom();
    wdata[CFG_BITS-1:0]   = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.note_config(sel, value);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rdata != CFG_DATA_BITS'(value)) begin
      $display("%0t: readback of register at %0d, expected %0d, actual %0d", $time,
               {sel, 2'b00}, value, rdata);
      readback_errors++;
    end
  endtask

  task automatic set_counts(input logic [CFG_BITS-1:0] procs, input logic [CFG_BITS-1:0] kinds);
    wait_idle();
    write_count(REG_PROC_COUNT, procs);
    write_count(REG_RES_COUNT, kinds);
  endtask

  // Well-formed loads with random content, runs now and then, a little noise;
  // always close with a run so the phase ends on checked verdicts.
  task automatic random_phase(input int words);
    int pick;
    repeat (words) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) start_scan();
      else if (pick < 16)
        offer_word(OP_UNUSED, INDEX_BITS'($urandom_range(0, 15)),
                   INDEX_BITS'($urandom_range(0, 15)), cnt_t'($urandom_range(0, 255)),
                   cnt_t'($urandom_range(0, 255)), cnt_t'($urandom_range(0, 255)));
      else if (pick < 40) load_free(pick_index(board.res_in_use()), pick_count());
      else load_row(pick_index(board.procs_in_use()), pick_index(board.res_in_use()),
                    pick_count(), pick_count());
    end
    start_scan();
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Zero counts act as one process and one resource.
    set_counts('0, '0);
    offer_word(OP_UNUSED, '1, '1, '1, '1, '1);
    load_free(0, '0);
    // A process holding nothing is done no matter what it asks for.
    load_row(0, 0, '0, '1);
    start_scan();
    // A holder asking for more than is free stays stuck.
    load_row(0, 0, '1, 8'd1);
    start_scan();

    // Classic circular wait: each process holds what the other wants.
    set_counts(5'd2, 5'd2);
    load_free(0, '0);
    load_free(1, '0);
    load_row(0, 0, 8'd1, 8'd0);
    load_row(0, 1, 8'd0, 8'd1);
    load_row(1, 0, 8'd0, 8'd1);
    load_row(1, 1, 8'd1, 8'd0);
    start_scan();
    // Free up the second resource: process 0 finishes, and its release frees process 1.
    load_free(1, '1);
    start_scan();

    // Random phases; counts above the table size act as the full table.
    for (int k = 0; k < 4; k++) begin
      case (k)
        1:       set_counts(5'd31, 5'd2);
        2:       set_counts(5'd1, 5'd20);
        default: set_counts(CFG_BITS'($urandom_range(0, 4)), CFG_BITS'($urandom_range(0, 3)));
      endcase
      if (k == 1) fill_tables(1'b1);
      random_phase(6);
    end

    wait_idle();
    if (board.errors == 0 && readback_errors == 0 && board.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Take verdicts with random stalls. Once, in the middle of a run while a
  // word waits at the input, hold off long enough to back the block up.
  initial begin : verdict_sink
    int unsigned gap;
    bit          hold_next;
    hold_next = 1'b0;
    @(negedge clk iff rst_n);
    forever begin
      gap       = hold_next ? HOLD_OFF_CYCLES : pick_gap(sink_calm);
      hold_next = 1'b0;
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      board.check_verdict(out_proc_id, out_is_deadlocked, out_any_deadlock, out_last);
      if (!held_off && !out_last && in_valid) begin
        held_off  = 1'b1;
        hold_next = 1'b1;
      end
      @(negedge clk);
    end
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/dd_pkg.sv
rtl/dd_tables.sv
rtl/dd_unit.sv
rtl/deadlock_detector.sv
dv/deadlock_detector_tb.sv
